// ----- hw/rtl/hpfl_pkg.sv -----
package hpfl_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam int PRESHIFT     = 14;
   localparam int MAG_W        = 16;
   // x grows by the CORDIC gain (about 1.65) plus sign headroom
   localparam int VEC_W        = MAG_W + PRESHIFT + 3;
   localparam int ANG_W        = 25;
   localparam int OUT_W        = 17;

   localparam logic signed [ANG_W-1:0] ANG_LIMIT = ANG_W'(90 * 65536);
   localparam logic signed [OUT_W-1:0] DEG_90    = OUT_W'(90 * 256);
   localparam logic signed [OUT_W-1:0] DEG_180   = OUT_W'(180 * 256);

   // atan(2^-i) in degrees, Q.16, rounded to nearest
   function automatic logic [ANG_W-1:0] atan_entry(input logic [4:0] idx);
      logic [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = ANG_W'(2949120);
         5'd1:  v = ANG_W'(1740967);
         5'd2:  v = ANG_W'(919879);
         5'd3:  v = ANG_W'(466945);
         5'd4:  v = ANG_W'(234379);
         5'd5:  v = ANG_W'(117304);
         5'd6:  v = ANG_W'(58666);
         5'd7:  v = ANG_W'(29335);
         5'd8:  v = ANG_W'(14668);
         5'd9:  v = ANG_W'(7334);
         5'd10: v = ANG_W'(3667);
         5'd11: v = ANG_W'(1833);
         5'd12: v = ANG_W'(917);
         5'd13: v = ANG_W'(458);
         5'd14: v = ANG_W'(229);
         5'd15: v = ANG_W'(115);
         5'd16: v = ANG_W'(57);
         5'd17: v = ANG_W'(29);
         5'd18: v = ANG_W'(14);
         5'd19: v = ANG_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/hpfl_cordic.sv -----
// Pipelined first-quadrant arctangent, one CORDIC iteration per stage.
// Input register, iteration stages and output register; accepts one pair every cycle.
module hpfl_cordic
   import hpfl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [MAG_W-1:0]        in_num,
   input  logic [MAG_W-1:0]        in_den,
   output logic                    out_valid,
   output logic signed [OUT_W-1:0] out_angle
);

   logic                    vld_ff [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] x_ff   [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] y_ff   [CORDIC_STEPS+1];
   logic signed [ANG_W-1:0] z_ff   [CORDIC_STEPS+1];
   logic                    num0_ff[CORDIC_STEPS+1];
   logic                    den0_ff[CORDIC_STEPS+1];
   logic                    ovld_ff;
   logic signed [OUT_W-1:0] oang_ff;
   logic signed [OUT_W-1:0] oang_in;
   logic signed [ANG_W-1:0] zc;
   logic signed [ANG_W:0]   zr;

   // load preshifted magnitudes
   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else       vld_ff[0] <= in_valid;
      x_ff[0]    <= {3'b000, in_den, {PRESHIFT{1'b0}}};
      y_ff[0]    <= {3'b000, in_num, {PRESHIFT{1'b0}}};
      z_ff[0]    <= '0;
      num0_ff[0] <= (in_num == '0);
      den0_ff[0] <= (in_den == '0);
   end

   // iterate, shifts truncate toward zero
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      logic signed [VEC_W-1:0] xs, ys;
      always_comb begin
         xs = x_ff[i][VEC_W-1] ? -((-x_ff[i]) >>> i) : (x_ff[i] >>> i);
         ys = y_ff[i][VEC_W-1] ? -((-y_ff[i]) >>> i) : (y_ff[i] >>> i);
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else       vld_ff[i+1] <= vld_ff[i];
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + ys;
            y_ff[i+1] <= y_ff[i] - xs;
            z_ff[i+1] <= z_ff[i] + $signed(atan_entry(5'(i)));
         end else begin
            x_ff[i+1] <= x_ff[i] - ys;
            y_ff[i+1] <= y_ff[i] + xs;
            z_ff[i+1] <= z_ff[i] - $signed(atan_entry(5'(i)));
         end
         num0_ff[i+1] <= num0_ff[i];
         den0_ff[i+1] <= den0_ff[i];
      end
   end

   // clamp, round to Q8.8, apply axis cases
   always_comb begin
      zc = z_ff[CORDIC_STEPS];
      if (zc < 0) zc = '0;
      if (zc > ANG_LIMIT) zc = ANG_LIMIT;
      zr = (ANG_W+1)'(zc) + (ANG_W+1)'(128);
      if (num0_ff[CORDIC_STEPS])      oang_in = '0;
      else if (den0_ff[CORDIC_STEPS]) oang_in = DEG_90;
      else                            oang_in = OUT_W'(zr >>> 8);
   end

   always_ff @(posedge clock) begin
      if (reset) ovld_ff <= 1'b0;
      else       ovld_ff <= vld_ff[CORDIC_STEPS];
      oang_ff <= oang_in;
   end

   assign out_valid = ovld_ff;
   assign out_angle = oang_ff;

`ifndef ASSERT_OFF
   a_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_angle >= 0 && out_angle <= DEG_90))
      else $error("angle out of first quadrant");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CORDIC_STEPS] |=> out_valid)
      else $error("valid lost at output stage");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[CORDIC_STEPS] && num0_ff[CORDIC_STEPS]) |=> out_angle == 0)
      else $error("zero numerator not zero angle");
`endif

endmodule

// ----- hw/rtl/head_pose_from_landmarks.sv -----
// Head pose from three landmarks: left eye, right eye, nose tip.
// Request channel: req_* coordinates (unsigned 12.4) are taken at a clock
// edge with start high and busy low. busy is always low here, so a new
// request may enter every cycle.
// Response channel: rsp_valid marks one cycle carrying rsp_roll_deg,
// rsp_yaw_deg (signed Q8.8 degrees) and rsp_degenerate. The receiver cannot
// stall; responses leave in request order.
// Pipeline: one difference stage, one sign stage, the CORDIC stages (input
// register, iterations, output register) and one combine stage.
// Throughput: one request per cycle, set by three parallel CORDIC pipelines,
// one for roll and one for each yaw term.
// Reset: synchronous, active high; clears all valid bits, dropping work in
// flight. No state survives between requests.
module head_pose_from_landmarks
   import hpfl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [15:0]             req_left_eye_x,
   input  logic [15:0]             req_left_eye_y,
   input  logic [15:0]             req_right_eye_x,
   input  logic [15:0]             req_right_eye_y,
   input  logic [15:0]             req_nose_x,
   input  logic [15:0]             req_nose_y,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_roll_deg,
   output logic signed [OUT_W-1:0] rsp_yaw_deg,
   output logic                    rsp_degenerate
);

   localparam int LAT = CORDIC_STEPS + 2;
   localparam int SD  = 17;

   typedef struct packed {
      logic roll_zero;  // coincident eyes
      logic roll_left;  // dx < 0
      logic roll_neg;   // dy < 0
      logic a1_neg;
      logic a1_d0;
      logic a1_n0;
      logic a2_neg;
      logic a2_d0;
      logic a2_n0;
   } ctl_type;

   logic                 vld0_ff, vld1_ff;
   logic signed [SD-1:0] dx_ff, dy_ff, n1_ff, d1_ff, n2_ff, d2_ff;
   logic [MAG_W-1:0]     mr_n_ff, mr_d_ff, m1_n_ff, m1_d_ff, m2_n_ff, m2_d_ff;
   ctl_type              ctl_in, ctl_ff;
   ctl_type              ctl_dly_ff [LAT];
   logic                 vr, v1, v2;
   logic signed [OUT_W-1:0] tr, t1, t2;
   logic signed [OUT_W-1:0] roll_in, a1, a2, yaw_in;
   logic                 ovld_ff, odeg_ff;
   logic signed [OUT_W-1:0] oroll_ff, oyaw_ff;

   assign busy = 1'b0;

   function automatic logic [MAG_W-1:0] mag(input logic signed [SD-1:0] v);
      logic signed [SD-1:0] a;
      a = v[SD-1] ? -v : v;
      return a[MAG_W-1:0];
   endfunction

   // take differences
   always_ff @(posedge clock) begin
      if (reset) vld0_ff <= 1'b0;
      else       vld0_ff <= start;
      dx_ff <= $signed({1'b0, req_right_eye_x}) - $signed({1'b0, req_left_eye_x});
      dy_ff <= $signed({1'b0, req_right_eye_y}) - $signed({1'b0, req_left_eye_y});
      n1_ff <= $signed({1'b0, req_nose_x}) - $signed({1'b0, req_left_eye_x});
      d1_ff <= $signed({1'b0, req_nose_y}) - $signed({1'b0, req_left_eye_y});
      n2_ff <= $signed({1'b0, req_right_eye_x}) - $signed({1'b0, req_nose_x});
      d2_ff <= $signed({1'b0, req_nose_y}) - $signed({1'b0, req_right_eye_y});
   end

   // split into magnitudes and sign flags
   always_comb begin
      ctl_in.roll_zero = (dx_ff == '0) && (dy_ff == '0);
      ctl_in.roll_left = dx_ff[SD-1];
      ctl_in.roll_neg  = dy_ff[SD-1];
      ctl_in.a1_neg    = n1_ff[SD-1] ^ d1_ff[SD-1];
      ctl_in.a1_d0     = (d1_ff == '0);
      ctl_in.a1_n0     = (n1_ff == '0);
      ctl_in.a2_neg    = n2_ff[SD-1] ^ d2_ff[SD-1];
      ctl_in.a2_d0     = (d2_ff == '0);
      ctl_in.a2_n0     = (n2_ff == '0);
      // for a zero denominator the sign follows the numerator alone
      if (ctl_in.a1_d0) ctl_in.a1_neg = n1_ff[SD-1];
      if (ctl_in.a2_d0) ctl_in.a2_neg = n2_ff[SD-1];
   end

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else       vld1_ff <= vld0_ff;
      mr_n_ff <= mag(dy_ff);
      mr_d_ff <= mag(dx_ff);
      m1_n_ff <= mag(n1_ff);
      m1_d_ff <= mag(d1_ff);
      m2_n_ff <= mag(n2_ff);
      m2_d_ff <= mag(d2_ff);
      ctl_ff  <= ctl_in;
   end

   hpfl_cordic u_roll (.clock(clock), .reset(reset), .in_valid(vld1_ff),
      .in_num(mr_n_ff), .in_den(mr_d_ff), .out_valid(vr), .out_angle(tr));
   hpfl_cordic u_a1 (.clock(clock), .reset(reset), .in_valid(vld1_ff),
      .in_num(m1_n_ff), .in_den(m1_d_ff), .out_valid(v1), .out_angle(t1));
   hpfl_cordic u_a2 (.clock(clock), .reset(reset), .in_valid(vld1_ff),
      .in_num(m2_n_ff), .in_den(m2_d_ff), .out_valid(v2), .out_angle(t2));

   // delay control flags alongside the CORDIC pipes
   always_ff @(posedge clock) begin
      ctl_dly_ff[0] <= ctl_ff;
      for (int k = 1; k < LAT; k++) ctl_dly_ff[k] <= ctl_dly_ff[k-1];
   end

   // apply quadrants and combine
   always_comb begin
      ctl_type c;
      c = ctl_dly_ff[LAT-1];
      if (c.roll_zero)      roll_in = '0;
      else if (c.roll_left) roll_in = DEG_180 - tr;
      else                  roll_in = tr;
      if (c.roll_neg) roll_in = -roll_in;
      if (c.a1_d0 && c.a1_n0) a1 = '0;
      else                    a1 = c.a1_neg ? -t1 : t1;
      if (c.a2_d0 && c.a2_n0) a2 = '0;
      else                    a2 = c.a2_neg ? -t2 : t2;
      yaw_in = a1 - a2;
   end

   always_ff @(posedge clock) begin
      if (reset) ovld_ff <= 1'b0;
      else       ovld_ff <= vr;
      oroll_ff <= roll_in;
      oyaw_ff  <= yaw_in;
      odeg_ff  <= (ctl_dly_ff[LAT-1].a1_d0 && ctl_dly_ff[LAT-1].a1_n0)
               || (ctl_dly_ff[LAT-1].a2_d0 && ctl_dly_ff[LAT-1].a2_n0);
   end

   assign rsp_valid      = ovld_ff;
   assign rsp_roll_deg   = oroll_ff;
   assign rsp_yaw_deg    = oyaw_ff;
   assign rsp_degenerate = odeg_ff;

`ifndef ASSERT_OFF
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      (vr == v1) && (vr == v2))
      else $error("CORDIC lanes out of step");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      vld1_ff |-> ##(LAT+1) rsp_valid)
      else $error("request lost in pipeline");
   a_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_deg >= -DEG_180 && rsp_roll_deg <= DEG_180))
      else $error("roll out of range");
`endif

endmodule

// ----- tb/sv/head_pose_from_landmarks_test.sv -----
`timescale 1ns / 1ps

module head_pose_from_landmarks_test;
   import hpfl_pkg::*;

   typedef struct {
      logic [15:0] lx, ly, rx, ry, nx, ny;
   } landmarks_type;

   typedef struct {
      logic signed [OUT_W-1:0] roll;
      logic signed [OUT_W-1:0] yaw;
      logic                    degen;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_left_eye_x = '0, req_left_eye_y = '0;
   logic [15:0] req_right_eye_x = '0, req_right_eye_y = '0;
   logic [15:0] req_nose_x = '0, req_nose_y = '0;
   logic rsp_valid;
   logic signed [OUT_W-1:0] rsp_roll_deg, rsp_yaw_deg;
   logic rsp_degenerate;

   landmarks_type pending_requests[$];
   pose_type      expected_poses[$];
   int            error_count = 0;
   bit            stimulus_done = 1'b0;
   bit            drain_hold = 1'b0;
   bit            drain_done = 1'b0;
   int            gap_left = 0;

   head_pose_from_landmarks u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_left_eye_x(req_left_eye_x), .req_left_eye_y(req_left_eye_y),
      .req_right_eye_x(req_right_eye_x), .req_right_eye_y(req_right_eye_y),
      .req_nose_x(req_nose_x), .req_nose_y(req_nose_y),
      .rsp_valid(rsp_valid), .rsp_roll_deg(rsp_roll_deg),
      .rsp_yaw_deg(rsp_yaw_deg), .rsp_degenerate(rsp_degenerate)
   );

   always #10 clock = ~clock;

   // first-quadrant arctangent of num/den in Q8.8 degrees
   function automatic int quadrant_atan(int unsigned num, int unsigned den);
      longint x, y, z, xs, ys;
      z = 0;
      if (num == 0) return 0;
      if (den == 0) return 90 * 256;
      x = longint'(den) << 14;
      y = longint'(num) << 14;
      for (int i = 0; i < 20; i++) begin
         xs = (x >= 0) ? (x >>> i) : -((-x) >>> i);
         ys = (y >= 0) ? (y >>> i) : -((-y) >>> i);
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(atan_entry(i[4:0]));
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(atan_entry(i[4:0]));
         end
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return int'((z + 128) >>> 8);
   endfunction

   function automatic int abs_int(int v);
      return (v < 0) ? -v : v;
   endfunction

   // signed ratio angle; flags zero over zero
   function automatic int side_angle(int n, int d, ref bit degen);
      int t;
      if (d == 0) begin
         if (n == 0) begin
            degen = 1'b1;
            return 0;
         end
         return (n > 0) ? 90 * 256 : -90 * 256;
      end
      t = quadrant_atan(abs_int(n), abs_int(d));
      return ((n < 0) != (d < 0)) ? -t : t;
   endfunction

   function automatic pose_type predict_pose(landmarks_type p);
      pose_type r;
      int dx, dy, t, roll, yaw;
      bit degen;
      degen = 1'b0;
      dx = int'(p.rx) - int'(p.lx);
      dy = int'(p.ry) - int'(p.ly);
      if (dx == 0 && dy == 0) begin
         roll = 0;
      end else begin
         t = quadrant_atan(abs_int(dy), abs_int(dx));
         roll = (dx >= 0) ? t : 180 * 256 - t;
         if (dy < 0) roll = -roll;
      end
      yaw = side_angle(int'(p.nx) - int'(p.lx), int'(p.ny) - int'(p.ly), degen)
          - side_angle(int'(p.rx) - int'(p.nx), int'(p.ny) - int'(p.ry), degen);
      r.roll = roll[OUT_W-1:0];
      r.yaw = yaw[OUT_W-1:0];
      r.degen = degen;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'(32768 + $urandom_range(0, 200) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_request(logic [15:0] lx, ly, rx, ry, nx, ny);
      landmarks_type p;
      p.lx = lx; p.ly = ly; p.rx = rx; p.ry = ry; p.nx = nx; p.ny = ny;
      pending_requests = {pending_requests, p};
   endtask

   // fill the request queue: directed corners and cases, then random coordinates and random faces
   initial begin
      logic [15:0] bx, by, c;
      add_request(0, 0, 0, 0, 0, 0);
      add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_request(100, 500, 900, 500, 500, 900);
      add_request(900, 500, 100, 500, 500, 900);
      add_request(0, 0, 16'hFFFF, 0, 0, 16'hFFFF);
      add_request(16'hFFFF, 0, 0, 0, 0, 0);
      add_request(0, 0, 0, 16'hFFFF, 16'hFFFF, 0);
      add_request(0, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF);
      add_request(100, 100, 300, 300, 200, 100);
      add_request(300, 300, 100, 100, 100, 300);
      add_request(100, 100, 300, 100, 100, 100);
      add_request(100, 100, 300, 100, 300, 100);
      add_request(500, 500, 500, 700, 800, 600);
      add_request(500, 700, 500, 500, 200, 600);
      add_request(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB);
      add_request(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hEDCB, 16'h1234);
      add_request(1000, 1000, 1001, 1000, 1000, 1001);
      add_request(1000, 1000, 1000, 1001, 999, 1000);
      for (int i = 0; i < 600; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            add_request(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), pick_coord());
         end else begin
            // plausible face, sometimes with shared coordinates
            bx = 16'($urandom_range(2000, 60000));
            by = 16'($urandom_range(2000, 60000));
            c = 16'($urandom_range(0, 1500));
            add_request(16'(bx - c), 16'(by + 16'($urandom_range(0, 200)) - 16'd100),
               16'(bx + c),
               ($urandom_range(0, 4) == 0) ? by
                  : 16'(by + 16'($urandom_range(0, 200)) - 16'd100),
               ($urandom_range(0, 4) == 0) ? 16'(bx - c)
                  : 16'(bx + 16'($urandom_range(0, 400)) - 16'd200),
               ($urandom_range(0, 4) == 0) ? by : 16'(by + 16'($urandom_range(0, 1500))));
         end
      end
   end

   // driver: present one request at a time, with random gaps
   always @(negedge clock) begin
      landmarks_type p;
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (drain_hold && expected_poses.size() != 0) begin
         start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
         if (pending_requests.size() == 300 && !drain_done) begin
            // hold off once until the pipeline is empty
            drain_hold <= 1'b1;
            drain_done <= 1'b1;
            start <= 1'b0;
         end else begin
            p = pending_requests.pop_front();
            req_left_eye_x <= p.lx; req_left_eye_y <= p.ly;
            req_right_eye_x <= p.rx; req_right_eye_y <= p.ry;
            req_nose_x <= p.nx; req_nose_y <= p.ny;
            start <= 1'b1;
            drain_hold <= 1'b0;
            // run back to back near the end
            gap_left <= (pending_requests.size() < 100 || $urandom_range(0, 2) == 0)
                        ? 0 : int'($urandom_range(0, 13));
         end
      end else begin
         start <= 1'b0;
         stimulus_done <= 1'b1;
      end
   end

   // monitor: record accepted requests and check responses
   always @(posedge clock) begin
      landmarks_type p;
      pose_type want;
      if (!reset) begin
         if (start && !busy) begin
            p.lx = req_left_eye_x; p.ly = req_left_eye_y;
            p.rx = req_right_eye_x; p.ry = req_right_eye_y;
            p.nx = req_nose_x; p.ny = req_nose_y;
            expected_poses = {expected_poses, predict_pose(p)};
         end
         if (rsp_valid) begin
            if (expected_poses.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_poses.pop_front();
               if (rsp_roll_deg !== want.roll)
                  report_mismatch("roll_deg", rsp_roll_deg, want.roll);
               if (rsp_yaw_deg !== want.yaw)
                  report_mismatch("yaw_deg", rsp_yaw_deg, want.yaw);
               if (rsp_degenerate !== want.degen)
                  report_mismatch("degenerate", rsp_degenerate, want.degen);
            end
         end
      end
   end

   // reset, then wait for the drain and finish
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && expected_poses.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/hpfl_pkg.sv
hw/rtl/hpfl_cordic.sv
hw/rtl/head_pose_from_landmarks.sv
tb/sv/head_pose_from_landmarks_test.sv
